// File: src/lfet_pkg.sv
package lfet_pkg;

    localparam int SAMPLE_W = 8;
    localparam int POWER_W  = 7;
    localparam int AREA_W   = 3;
    localparam int TRANS_W  = 4;
    localparam int STEER_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STRAIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SLOW     = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_BASE_THRESHOLD = 8'd0;
    localparam logic [SAMPLE_W-1:0] RST_LOST_LIMIT     = 8'd200;
    localparam logic [POWER_W-1:0]  RST_SPEED_STRAIGHT = 7'd30;
    localparam logic [POWER_W-1:0]  RST_SPEED_FAST     = 7'd40;
    localparam logic [POWER_W-1:0]  RST_SPEED_SLOW     = 7'd5;

    // band limits
    localparam logic [SAMPLE_W-1:0] BASE_MIN   = 8'd15;
    localparam logic [SAMPLE_W-1:0] BAND_HALF  = 8'd10;
    localparam logic [SAMPLE_W-1:0] DEF_UPPER  = 8'd20;
    localparam logic [SAMPLE_W-1:0] DEF_LOWER  = 8'd10;

    // areas
    localparam logic [AREA_W-1:0] AREA_LOST   = 3'd0;
    localparam logic [AREA_W-1:0] AREA_RWHITE = 3'd1;
    localparam logic [AREA_W-1:0] AREA_REDGE  = 3'd2;
    localparam logic [AREA_W-1:0] AREA_BLACK  = 3'd3;
    localparam logic [AREA_W-1:0] AREA_LEDGE  = 3'd4;
    localparam logic [AREA_W-1:0] AREA_LWHITE = 3'd5;

    // transitions
    localparam logic [TRANS_W-1:0] TR_IDLE  = 4'd0;
    localparam logic [TRANS_W-1:0] TR_RW_RE = 4'd1;
    localparam logic [TRANS_W-1:0] TR_RE_RW = 4'd2;
    localparam logic [TRANS_W-1:0] TR_RE_B  = 4'd3;
    localparam logic [TRANS_W-1:0] TR_B_RE  = 4'd4;
    localparam logic [TRANS_W-1:0] TR_LW_LE = 4'd5;
    localparam logic [TRANS_W-1:0] TR_LE_LW = 4'd6;
    localparam logic [TRANS_W-1:0] TR_B_LE  = 4'd7;
    localparam logic [TRANS_W-1:0] TR_LE_B  = 4'd8;

    // steering
    localparam logic [STEER_W-1:0] STEER_STRAIGHT = 2'd0;
    localparam logic [STEER_W-1:0] STEER_RIGHT    = 2'd1;
    localparam logic [STEER_W-1:0] STEER_LEFT     = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] base_threshold;
        logic [SAMPLE_W-1:0] lost_limit;
        logic [POWER_W-1:0]  speed_straight;
        logic [POWER_W-1:0]  speed_fast;
        logic [POWER_W-1:0]  speed_slow;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] last_sample;
        logic [AREA_W-1:0]   last_area;
        logic [TRANS_W-1:0]  last_trans;
        logic [SAMPLE_W-1:0] white_run;
        logic [POWER_W-1:0]  right_drive;
        logic [POWER_W-1:0]  left_drive;
        logic [STEER_W-1:0]  last_steer;
    } t_state;

    typedef struct packed {
        logic               changed;
        logic               right_update;
        logic               left_update;
        logic [POWER_W-1:0] right_power;
        logic [POWER_W-1:0] left_power;
        logic [AREA_W-1:0]  area;
        logic [STEER_W-1:0] steer;
    } t_result;

    function automatic logic [STEER_W-1:0] steer_of(input logic [TRANS_W-1:0] trans);
        logic [STEER_W-1:0] s;
        case (trans) inside
            TR_RE_B, TR_LW_LE, TR_LE_B, TR_LE_LW: s = STEER_RIGHT;
            TR_RE_RW:                             s = STEER_LEFT;
            default:                              s = STEER_STRAIGHT;
        endcase
        return s;
    endfunction

endpackage

// File: src/lfet_in_if.sv
interface lfet_in_if
    import lfet_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: src/lfet_out_if.sv
interface lfet_out_if
    import lfet_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               changed;
    logic               right_update;
    logic               left_update;
    logic [POWER_W-1:0] right_power;
    logic [POWER_W-1:0] left_power;
    logic [AREA_W-1:0]  area;
    logic [STEER_W-1:0] steer;

    modport source (output valid, output changed, output right_update, output left_update,
                    output right_power, output left_power, output area, output steer,
                    input ready);
    modport sink   (input valid, input changed, input right_update, input left_update,
                    input right_power, input left_power, input area, input steer,
                    output ready);
endinterface

// File: src/line_follow_edge_tracker.sv
// Channel      Dir  Payload                                            Transfer
// i_sample_ch  in   sample[7:0]                                        valid & ready
// o_result_ch  out  changed, right_update, left_update, right_power,   valid & ready
//                   left_power, area, steer
//
// One sample per clock; its result is registered. The tracking state updates in the same
// cycle a sample is taken, so samples may follow back to back. A two-entry output buffer
// (result register plus skid register) lets the input keep taking samples while a result
// waits; input ready drops only when both hold. Synchronous reset clears tracking state,
// loads register defaults and empties the buffer.
module line_follow_edge_tracker
    import lfet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lfet_in_if.sink               i_sample_ch,
    lfet_out_if.source            o_result_ch
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_xfer;
    logic    out_xfer;

    lfet_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (i_sample_ch.sample),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign i_sample_ch.ready = !r_skid_valid;
    assign in_xfer  = i_sample_ch.valid && !r_skid_valid;
    assign out_xfer = r_out_valid && o_result_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_threshold <= RST_BASE_THRESHOLD;
            r_cfg.lost_limit     <= RST_LOST_LIMIT;
            r_cfg.speed_straight <= RST_SPEED_STRAIGHT;
            r_cfg.speed_fast     <= RST_SPEED_FAST;
            r_cfg.speed_slow     <= RST_SPEED_SLOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_THRESHOLD: r_cfg.base_threshold <= i_cfg_data;
                CFG_LOST_LIMIT:     r_cfg.lost_limit     <= i_cfg_data;
                CFG_SPEED_STRAIGHT: r_cfg.speed_straight <= i_cfg_data[POWER_W-1:0];
                CFG_SPEED_FAST:     r_cfg.speed_fast     <= i_cfg_data[POWER_W-1:0];
                CFG_SPEED_SLOW:     r_cfg.speed_slow     <= i_cfg_data[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_sample <= '0;
            r_state.last_area   <= AREA_RWHITE;
            r_state.last_trans  <= TR_IDLE;
            r_state.white_run   <= '0;
            r_state.right_drive <= '0;
            r_state.left_drive  <= '0;
            r_state.last_steer  <= STEER_STRAIGHT;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain skid into the output register
            if (out_xfer) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.changed      = r_out.changed;
    assign o_result_ch.right_update = r_out.right_update;
    assign o_result_ch.left_update  = r_out.left_update;
    assign o_result_ch.right_power  = r_out.right_power;
    assign o_result_ch.left_power   = r_out.left_power;
    assign o_result_ch.area         = r_out.area;
    assign o_result_ch.steer        = r_out.steer;

endmodule

// File: src/lfet_step.sv
module lfet_step
    import lfet_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_state              o_state,
    output t_result             o_result
);

    logic [SAMPLE_W:0]   hi_sum;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;

    always_comb begin
        hi_sum = {1'b0, i_cfg.base_threshold} + {1'b0, BAND_HALF};
        if (i_cfg.base_threshold > BASE_MIN) begin
            hi = hi_sum[SAMPLE_W] ? '1 : hi_sum[SAMPLE_W-1:0];
            lo = i_cfg.base_threshold - BAND_HALF;
        end else begin
            hi = DEF_UPPER;
            lo = DEF_LOWER;
        end
    end

    always_comb begin
        logic               chg;
        logic [AREA_W-1:0]  area;
        logic [TRANS_W-1:0] trans;
        logic [SAMPLE_W-1:0] run;
        logic [STEER_W-1:0] steer;
        logic [POWER_W-1:0] rp;
        logic [POWER_W-1:0] lp;

        chg   = 1'b0;
        area  = i_state.last_area;
        trans = i_state.last_trans;
        run   = i_state.white_run;

        if (i_sample > hi) begin
            if (i_state.last_sample <= hi) begin
                chg = 1'b1;
                run = '0;
                if (i_state.last_area == AREA_REDGE) begin
                    trans = TR_RE_RW;
                    area  = AREA_RWHITE;
                end else begin
                    trans = TR_LE_LW;
                    area  = AREA_LWHITE;
                end
            end
        end else if (i_sample < lo) begin
            if (i_state.last_sample >= lo) begin
                chg   = 1'b1;
                area  = AREA_BLACK;
                trans = (i_state.last_area == AREA_REDGE) ? TR_RE_B : TR_LE_B;
            end
        end else begin
            if (i_state.last_sample > hi) begin
                chg = 1'b1;
                if (i_state.last_area == AREA_RWHITE) begin
                    trans = TR_RW_RE;
                    area  = AREA_REDGE;
                end else begin
                    trans = TR_LW_LE;
                    area  = AREA_LEDGE;
                end
            end else if (i_state.last_trans != TR_B_RE) begin
                chg   = 1'b1;
                trans = TR_B_RE;
                area  = AREA_REDGE;
            end
        end

        // white run with no crossing: count, or declare the line lost
        if (!chg && (area == AREA_RWHITE || area == AREA_LWHITE || area == AREA_LOST)) begin
            if (run >= i_cfg.lost_limit) begin
                run   = '0;
                area  = AREA_LOST;
                trans = TR_IDLE;
                chg   = 1'b1;
            end else begin
                run = run + 1'b1;
            end
        end

        steer = steer_of(trans);
        if (steer == STEER_RIGHT) begin
            rp = i_cfg.speed_slow;
            lp = i_cfg.speed_fast;
        end else if (steer == STEER_LEFT) begin
            rp = i_cfg.speed_fast;
            lp = i_cfg.speed_slow;
        end else begin
            rp = i_cfg.speed_straight;
            lp = i_cfg.speed_straight;
        end

        o_state.last_sample = i_sample;
        o_state.last_area   = area;
        o_state.last_trans  = trans;
        o_state.white_run   = run;
        o_state.right_drive = chg ? rp : i_state.right_drive;
        o_state.left_drive  = chg ? lp : i_state.left_drive;
        o_state.last_steer  = chg ? steer : i_state.last_steer;

        o_result.changed      = chg;
        o_result.right_update = chg && (rp != i_state.right_drive);
        o_result.left_update  = chg && (lp != i_state.left_drive);
        o_result.right_power  = o_state.right_drive;
        o_result.left_power   = o_state.left_drive;
        o_result.area         = area;
        o_result.steer        = o_state.last_steer;
    end

endmodule

// File: tb/sv/tb_line_follow_edge_tracker.sv
module tb_line_follow_edge_tracker
    import lfet_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {BAND_WHITE, BAND_EDGE, BAND_BLACK} t_band;

    // Tracks the expected steering results of every accepted sample.
    class steer_scoreboard;
        t_cfg    cfg;
        t_state  st;
        t_result expected_steering[$];
        int      errors;
        int      checked;
        int      changes_seen;
        int      losses_seen;

        function new();
            cfg.base_threshold = RST_BASE_THRESHOLD;
            cfg.lost_limit     = RST_LOST_LIMIT;
            cfg.speed_straight = RST_SPEED_STRAIGHT;
            cfg.speed_fast     = RST_SPEED_FAST;
            cfg.speed_slow     = RST_SPEED_SLOW;
            st = '0;
            st.last_area  = AREA_RWHITE;
            st.last_trans = TR_IDLE;
            st.last_steer = STEER_STRAIGHT;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BASE_THRESHOLD: cfg.base_threshold = val;
                CFG_LOST_LIMIT:     cfg.lost_limit     = val;
                CFG_SPEED_STRAIGHT: cfg.speed_straight = val[POWER_W-1:0];
                CFG_SPEED_FAST:     cfg.speed_fast     = val[POWER_W-1:0];
                CFG_SPEED_SLOW:     cfg.speed_slow     = val[POWER_W-1:0];
                default: ;
            endcase
        endfunction

        function void band_limits(output int hi, output int lo);
            if (cfg.base_threshold > BASE_MIN) begin
                hi = int'(cfg.base_threshold) + int'(BAND_HALF);
                if (hi > 255) hi = 255;
                lo = int'(cfg.base_threshold) - int'(BAND_HALF);
            end else begin
                hi = int'(DEF_UPPER);
                lo = int'(DEF_LOWER);
            end
        endfunction

        function t_result predict_steering(logic [SAMPLE_W-1:0] s);
            int                 hi, lo, cur, prev;
            logic [AREA_W-1:0]  area;
            logic [TRANS_W-1:0] trans;
            logic [STEER_W-1:0] dir;
            logic [POWER_W-1:0] rp, lp;
            logic               chg;
            t_result            r;
            band_limits(hi, lo);
            cur   = int'(s);
            prev  = int'(st.last_sample);
            area  = st.last_area;
            trans = st.last_trans;
            chg   = 1'b0;
            r     = '0;

            if (cur > hi) begin
                if (prev <= hi) begin
                    chg = 1'b1;
                    st.white_run = '0;
                    if (st.last_area == AREA_REDGE) begin
                        trans = TR_RE_RW;
                        area  = AREA_RWHITE;
                    end else begin
                        trans = TR_LE_LW;
                        area  = AREA_LWHITE;
                    end
                end
            end else if (cur < lo) begin
                if (prev >= lo) begin
                    chg   = 1'b1;
                    area  = AREA_BLACK;
                    trans = (st.last_area == AREA_REDGE) ? TR_RE_B : TR_LE_B;
                end
            end else if (prev > hi) begin
                chg = 1'b1;
                if (st.last_area == AREA_RWHITE) begin
                    trans = TR_RW_RE;
                    area  = AREA_REDGE;
                end else begin
                    trans = TR_LW_LE;
                    area  = AREA_LEDGE;
                end
            end else if (st.last_trans != TR_B_RE) begin
                chg   = 1'b1;
                trans = TR_B_RE;
                area  = AREA_REDGE;
            end

            // count white samples with no crossing; past the limit the line is lost
            if (!chg && (area == AREA_RWHITE || area == AREA_LWHITE || area == AREA_LOST)) begin
                if (st.white_run >= cfg.lost_limit) begin
                    st.white_run = '0;
                    area  = AREA_LOST;
                    trans = TR_IDLE;
                    chg   = 1'b1;
                    losses_seen++;
                end else begin
                    st.white_run = st.white_run + 1'b1;
                end
            end

            if (chg) begin
                case (trans)
                    TR_RE_B, TR_LW_LE, TR_LE_B, TR_LE_LW: dir = STEER_RIGHT;
                    TR_RE_RW:                             dir = STEER_LEFT;
                    default:                              dir = STEER_STRAIGHT;
                endcase
                if (dir == STEER_RIGHT) begin
                    rp = cfg.speed_slow;
                    lp = cfg.speed_fast;
                end else if (dir == STEER_LEFT) begin
                    rp = cfg.speed_fast;
                    lp = cfg.speed_slow;
                end else begin
                    rp = cfg.speed_straight;
                    lp = cfg.speed_straight;
                end
                r.right_update = (rp != st.right_drive);
                r.left_update  = (lp != st.left_drive);
                st.right_drive = rp;
                st.left_drive  = lp;
                st.last_steer  = dir;
                changes_seen++;
            end

            st.last_area   = area;
            st.last_sample = s;
            st.last_trans  = trans;

            r.changed     = chg;
            r.right_power = st.right_drive;
            r.left_power  = st.left_drive;
            r.area        = area;
            r.steer       = st.last_steer;
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            expected_steering.push_back(predict_steering(s));
        endfunction

        function int pending();
            return expected_steering.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 30) $display("MISMATCH at result %0d: %s", checked, what);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            checked++;
            if (expected_steering.size() == 0) begin
                report_mismatch("result with no sample outstanding");
                return;
            end
            want = expected_steering.pop_front();
            compare_field("changed",      8'(got.changed),      8'(want.changed));
            compare_field("right_update", 8'(got.right_update), 8'(want.right_update));
            compare_field("left_update",  8'(got.left_update),  8'(want.left_update));
            compare_field("right_power",  8'(got.right_power),  8'(want.right_power));
            compare_field("left_power",   8'(got.left_power),   8'(want.left_power));
            compare_field("area",         8'(got.area),         8'(want.area));
            compare_field("steer",        8'(got.steer),        8'(want.steer));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfet_in_if  sample_ch();
    lfet_out_if result_ch();

    steer_scoreboard sb = new();

    bit quiet;
    bit hold_request;
    int samples_sent;
    int settings_run;
    int long_holds;

    line_follow_edge_tracker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("tb_line_follow_edge_tracker failed");
        $finish;
    end

    always @(posedge clk) begin
        t_result got;
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready) sb.note_sample(sample_ch.sample);
            if (result_ch.valid && result_ch.ready) begin
                got.changed      = result_ch.changed;
                got.right_update = result_ch.right_update;
                got.left_update  = result_ch.left_update;
                got.right_power  = result_ch.right_power;
                got.left_power   = result_ch.left_power;
                got.area         = result_ch.area;
                got.steer        = result_ch.steer;
                sb.check_result(got);
            end
        end
    end

    // result sink: random stalls, plus one long hold-off on request
    initial begin
        int stall_len;
        result_ch.ready = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                @(negedge clk);
                result_ch.ready = 1'b0;
                repeat (79) @(negedge clk);
            end else if (quiet || $urandom_range(0, 99) < 70) begin
                @(negedge clk);
                result_ch.ready = 1'b1;
                stall_len = $urandom_range(0, 15);
                repeat (stall_len) @(negedge clk);
            end else begin
                stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
                @(negedge clk);
                result_ch.ready = 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            sample_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid  = 1'b1;
        sample_ch.sample = s;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        samples_sent++;
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] band_sample(t_band b);
        int hi, lo;
        bit on_edge;
        sb.band_limits(hi, lo);
        on_edge = ($urandom_range(0, 3) == 0);
        if (b == BAND_WHITE && hi < 255)
            return on_edge ? SAMPLE_W'(hi + 1) : SAMPLE_W'($urandom_range(255, hi + 1));
        if (b == BAND_BLACK)
            return on_edge ? SAMPLE_W'(lo - 1) : SAMPLE_W'($urandom_range(lo - 1, 0));
        if (on_edge) return $urandom_range(0, 1) ? SAMPLE_W'(hi) : SAMPLE_W'(lo);
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    // sweeps across the line: mostly neighboring bands, some jumps, some noise
    task automatic run_sweeps(input int count);
        int    sent;
        int    dwell;
        t_band band;
        sent = 0;
        band = BAND_EDGE;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(SAMPLE_W'($urandom));
                sent++;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    band = t_band'($urandom_range(0, 2));
                else if (band == BAND_EDGE)
                    band = $urandom_range(0, 1) ? BAND_WHITE : BAND_BLACK;
                else
                    band = BAND_EDGE;
                if ($urandom_range(0, 7) == 0)
                    dwell = (band == BAND_WHITE) ? $urandom_range(1, int'(sb.cfg.lost_limit) + 3)
                                                 : $urandom_range(7, 30);
                else
                    dwell = $urandom_range(1, 6);
                while (dwell > 0 && sent < count) begin
                    send_sample(band_sample(band));
                    sent++;
                    dwell--;
                end
            end
        end
    endtask

    task automatic run_setting(input logic [7:0] base, input logic [7:0] lost,
                               input logic [7:0] straight, input logic [7:0] fast,
                               input logic [7:0] slow, input int count);
        write_reg(CFG_BASE_THRESHOLD, base);
        write_reg(CFG_LOST_LIMIT, lost);
        write_reg(CFG_SPEED_STRAIGHT, straight);
        write_reg(CFG_SPEED_FAST, fast);
        write_reg(CFG_SPEED_SLOW, slow);
        settings_run++;
        run_sweeps(count);
        drain();
    endtask

    initial begin
        logic [SAMPLE_W-1:0] directed[$];
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits are 20 and 10: hit both sides of each, repeats and full-scale jumps
        directed = '{8'd0, 8'd255, 8'd21, 8'd20, 8'd10, 8'd9, 8'd0, 8'd10, 8'd15, 8'd20,
                     8'd21, 8'd255, 8'd128, 8'd20, 8'd9, 8'd10, 8'd11, 8'd19, 8'd21,
                     8'd254, 8'd1, 8'd0, 8'd170, 8'd85};
        foreach (directed[k]) send_sample(directed[k]);
        drain();
        settings_run++;

        // zero lost limit, with the sink holding off long enough to back up the input
        hold_request = 1'b1;
        run_setting(8'd16, 8'd0, 8'd0, 8'd100, 8'd0, 160);
        quiet = 1'b1;
        run_setting(8'd15, 8'd1, 8'd100, 8'd0, 8'd100, 160);
        quiet = 1'b0;
        run_setting(8'd100, 8'd255, 8'd30, 8'd40, 8'd5, 320);
        // upper limit saturates at full scale
        run_setting(8'd250, 8'd3, 8'd127, 8'd127, 8'd0, 140);
        run_setting(8'd255, 8'd2, 8'd1, 8'd2, 8'd3, 100);
        run_setting(8'd0, 8'd200, 8'd64, 8'd101, 8'd63, 180);
        run_setting(8'($urandom), 8'($urandom_range(0, 60)), 8'($urandom_range(0, 127)),
                    8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)), 180);
        run_setting(8'd245, 8'd10, 8'($urandom_range(0, 100)), 8'($urandom_range(0, 100)),
                    8'($urandom_range(0, 100)), 200);

        repeat (5) @(posedge clk);
        $display("Run covered %0d samples under %0d register settings, %0d results checked.",
                 samples_sent, settings_run, sb.checked);
        $display("Saw %0d band changes, %0d line losses and %0d long output hold-offs.",
                 sb.changes_seen, sb.losses_seen, long_holds);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_line_follow_edge_tracker passed");
        else
            $display("tb_line_follow_edge_tracker failed");
        $finish;
    end
endmodule
